// ----- sv/kyr_pkg.sv -----
package kyr_pkg;

	localparam int unsigned DASH_LENGTH   = 3;
	localparam int unsigned COUNTER_WIDTH = 8;
	localparam int unsigned RESET_COUNT   = 159;
	localparam int unsigned SPEED_WIDTH   = 8;

	typedef logic [COUNTER_WIDTH-1:0] counter_t;
	typedef logic [1:0]               dash_count_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_DOT      = 3'd1,
		PH_DASH     = 3'd2,
		PH_GAP_DOT  = 3'd3,
		PH_GAP_DASH = 3'd4
	} phase_t;

	// one input word as held in the input register
	typedef struct packed {
		logic                   tick;
		logic                   dot_pressed;
		logic                   dash_pressed;
		logic                   speed_valid;
		logic [SPEED_WIDTH-1:0] speed_value;
	} item_t;

endpackage

// ----- sv/kyr_core.sv -----
module kyr_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  kyr_pkg::item_t item,
	output logic          key_level,
	output kyr_pkg::phase_t phase
);

	kyr_pkg::phase_t      phase_q, pend_q;
	kyr_pkg::dash_count_t dash_q;
	kyr_pkg::counter_t    cnt_q, reload_q;
	logic                 key_q;

	kyr_pkg::phase_t      phase_d, pend_d;
	kyr_pkg::dash_count_t dash_d;
	kyr_pkg::counter_t    cnt_d, reload_d;
	logic                 key_d;

	always_comb begin
		phase_d  = phase_q;
		pend_d   = pend_q;
		dash_d   = dash_q;
		cnt_d    = cnt_q;
		reload_d = reload_q;
		key_d    = key_q;

		// timebase tick and wrap
		if (item.tick) begin
			if (cnt_q == '1) begin
				cnt_d   = reload_q;
				phase_d = pend_q;
				case (pend_q)
					kyr_pkg::PH_DOT: begin
						key_d  = 1'b1;
						pend_d = kyr_pkg::PH_GAP_DOT;
					end
					kyr_pkg::PH_DASH: begin
						key_d  = 1'b1;
						dash_d = dash_q + 2'd1;
						if (dash_d >= kyr_pkg::dash_count_t'(kyr_pkg::DASH_LENGTH)) begin
							dash_d = '0;
							pend_d = kyr_pkg::PH_GAP_DASH;
						end else begin
							pend_d = kyr_pkg::PH_DASH;
						end
					end
					kyr_pkg::PH_GAP_DOT, kyr_pkg::PH_GAP_DASH: begin
						key_d = 1'b0;
					end
					default: begin
						phase_d = kyr_pkg::PH_IDLE;
						pend_d  = kyr_pkg::PH_IDLE;
						key_d   = 1'b0;
					end
				endcase
			end else begin
				cnt_d = cnt_q + kyr_pkg::counter_t'(1);
			end
		end

		// new speed sample, used from the next wrap
		if (item.speed_valid) begin
			reload_d = kyr_pkg::counter_t'(0) - kyr_pkg::counter_t'(item.speed_value);
		end

		// paddle polling against the phase just set
		case (phase_d)
			kyr_pkg::PH_GAP_DASH: begin
				pend_d = item.dot_pressed  ? kyr_pkg::PH_DOT :
				         item.dash_pressed ? kyr_pkg::PH_DASH : kyr_pkg::PH_IDLE;
			end
			kyr_pkg::PH_IDLE, kyr_pkg::PH_GAP_DOT: begin
				pend_d = item.dash_pressed ? kyr_pkg::PH_DASH :
				         item.dot_pressed  ? kyr_pkg::PH_DOT : kyr_pkg::PH_IDLE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= kyr_pkg::PH_IDLE;
			pend_q   <= kyr_pkg::PH_IDLE;
			dash_q   <= '0;
			cnt_q    <= kyr_pkg::counter_t'(kyr_pkg::RESET_COUNT);
			reload_q <= kyr_pkg::counter_t'(kyr_pkg::RESET_COUNT);
			key_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			pend_q   <= pend_d;
			dash_q   <= dash_d;
			cnt_q    <= cnt_d;
			reload_q <= reload_d;
			key_q    <= key_d;
		end
	end

	assign key_level = key_q;
	assign phase     = phase_q;

endmodule

// ----- sv/iambic_keyer_unit.sv -----
// iambic morse keyer, mode a, with programmable dot period
// input channel: in_valid / in_stall carry one word per timebase sample:
//   tick, both paddle levels and an optional speed sample
// output channel: out_valid / out_stall carry one result word per input word:
//   key_out, sidetone_on (same as key_out) and keyer_phase
// a word accepted sits in the input register; the keyer state steps from it
// once the result slot is free or being taken, and the result register
// then shows the new state
// throughput is one word per cycle unless stalled: the state step is a single
// short pass of counter compare, phase select and paddle priority logic
// the keyer state registers double as the result register; they only step
// when the result slot is free or being taken
// when the receiver stalls, the result holds, one further word waits in the
// input register and in_stall rises until out_stall drops
// reset clears both valid flags, sets the keyer idle and unkeyed and loads
// the period counter and reload value with 159
module iambic_keyer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       tick,
	input  logic       dot_pressed,
	input  logic       dash_pressed,
	input  logic       speed_valid,
	input  logic [7:0] speed_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       key_out,
	output logic       sidetone_on,
	output logic [2:0] keyer_phase
);

	// input register
	kyr_pkg::item_t item_s1;
	logic           valid_s1;

	// result slot
	logic           out_valid_q;
	logic           out_free;
	logic           step;
	logic           key_level;
	kyr_pkg::phase_t phase;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.tick         <= tick;
			item_s1.dot_pressed  <= dot_pressed;
			item_s1.dash_pressed <= dash_pressed;
			item_s1.speed_valid  <= speed_valid;
			item_s1.speed_value  <= speed_value;
		end
	end

	kyr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.key_level (key_level),
		.phase     (phase)
	);

	assign out_valid   = out_valid_q;
	assign key_out     = key_level;
	assign sidetone_on = key_level;
	assign keyer_phase = phase;

`ifndef SYNTHESIS
	// keyed exactly while in a dot or dash element
	a_key_phase: assert property (@(posedge clk) disable iff (!arst_n)
		key_out == (keyer_phase == kyr_pkg::PH_DOT || keyer_phase == kyr_pkg::PH_DASH))
		else $error("key line disagrees with phase");

	// a held result does not change under stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(key_out) && $stable(keyer_phase)))
		else $error("result changed while stalled");

	// input only stalls when a word is waiting and the result slot is blocked
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with free result slot");

	// a waiting word with a free slot always produces a result next cycle
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_free) |=> out_valid)
		else $error("word lost between stages");
`endif

endmodule

// ----- dv/tb_iambic_keyer_unit.sv -----
`timescale 1ns / 100ps

module tb_iambic_keyer_unit;
	import kyr_pkg::*;

	// run shape
	localparam int unsigned RANDOM_WORDS = 583;
	localparam int unsigned PAUSE_AT     = 250;   // sender drains the keyer here
	localparam int unsigned HOLD_AT      = 330;   // receiver holds off from this word count
	localparam int unsigned HOLD_CYCLES  = 40;
	localparam int unsigned CALM_FROM    = 420;   // no idling on either side in this span
	localparam int unsigned CALM_TO      = 560;
	localparam int unsigned IDLE_PCT     = 12;
	localparam int unsigned TAIL_CYCLES  = 8;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRILL_ROWS   = 23;

	// what the keyer shows after one word
	typedef struct packed {
		logic   key_on;
		logic   tone_on;
		phase_t phase;
	} key_result_t;

	// one line of the directed drill: a word, how often it is sent and,
	// where it is obvious, the result it must give
	typedef struct {
		int unsigned reps;
		item_t       w;
		bit          typed;
		key_result_t res;
	} drill_row_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   in_valid     = 1'b0;
	logic                   in_stall;
	logic                   tick         = 1'b0;
	logic                   dot_pressed  = 1'b0;
	logic                   dash_pressed = 1'b0;
	logic                   speed_valid  = 1'b0;
	logic [SPEED_WIDTH-1:0] speed_value  = '0;
	logic                   out_valid;
	logic                   out_stall    = 1'b0;
	logic                   key_out;
	logic                   sidetone_on;
	logic [2:0]             keyer_phase;

	// keyer state as the testbench sees it
	phase_t      kp_phase;
	phase_t      kp_pending;
	dash_count_t kp_dash_cnt;
	counter_t    kp_count;
	counter_t    kp_reload;
	logic        kp_key;

	key_result_t key_results_due[$];
	key_result_t want;
	int unsigned words_taken = 0;
	int unsigned mismatches  = 0;
	int unsigned cycles_run  = 0;
	bit          calm        = 1'b0;

	// directed drill; the period counter starts at 159, so a long run of ticks
	// brings it up to the first wrap, by which time the period is one tick
	drill_row_t drill [DRILL_ROWS] = '{
		// straight out of reset, nothing happening
		'{1,  '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0},   1'b1, '{1'b0, 1'b0, PH_IDLE}},
		// all-ones speed and both paddles, no tick
		'{1,  '{1'b0, 1'b1, 1'b1, 1'b1, 8'd255}, 1'b1, '{1'b0, 1'b0, PH_IDLE}},
		// speed zero, meaning a full 256-tick period
		'{1,  '{1'b0, 1'b0, 1'b0, 1'b1, 8'd0},   1'b1, '{1'b0, 1'b0, PH_IDLE}},
		// speed one: every tick wraps once the first wrap has loaded it
		'{1,  '{1'b0, 1'b0, 1'b0, 1'b1, 8'd1},   1'b1, '{1'b0, 1'b0, PH_IDLE}},
		// run-up: counter 159 to 254
		'{95, '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b1, '{1'b0, 1'b0, PH_IDLE}},
		// counter reaches all ones, dot polled while idle
		'{1,  '{1'b1, 1'b1, 1'b0, 1'b0, 8'd0},   1'b1, '{1'b0, 1'b0, PH_IDLE}},
		// first wrap: dot keyed
		'{1,  '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		// gap after dot, dash polled
		'{1,  '{1'b1, 1'b0, 1'b1, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		// three dash periods, paddles ignored while keyed
		'{1,  '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		'{1,  '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		'{1,  '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		// gap after dash, squeeze gives the dot priority
		'{1,  '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		// no tick: counter holds, dash alone re-polled
		'{1,  '{1'b0, 1'b0, 1'b1, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		'{1,  '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		'{1,  '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		'{1,  '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		// gap after dash with paddles open
		'{1,  '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		// back to idle
		'{1,  '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b1, '{1'b0, 1'b0, PH_IDLE}},
		// idle squeeze: dash wins
		'{1,  '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		// dot alone overrides, speed two for the following periods
		'{1,  '{1'b0, 1'b1, 1'b0, 1'b1, 8'd2},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		'{1,  '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		// mid-period, still keyed
		'{1,  '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0},   1'b0, '{1'b0, 1'b0, PH_IDLE}},
		'{1,  '{1'b1, 1'b1, 1'b0, 1'b1, 8'd3},   1'b0, '{1'b0, 1'b0, PH_IDLE}}
	};

	iambic_keyer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.tick         (tick),
		.dot_pressed  (dot_pressed),
		.dash_pressed (dash_pressed),
		.speed_valid  (speed_valid),
		.speed_value  (speed_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_out      (key_out),
		.sidetone_on  (sidetone_on),
		.keyer_phase  (keyer_phase)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// steps the keyer state by one word and returns what it then shows
	function automatic key_result_t step_keyer(item_t w);
		key_result_t r;
		if (w.tick) begin
			if (kp_count == '1) begin
				// wrap: reload and move on to the queued phase
				kp_count = kp_reload;
				kp_phase = kp_pending;
				case (kp_phase)
					PH_DOT: begin
						kp_key     = 1'b1;
						kp_pending = PH_GAP_DOT;
					end
					PH_DASH: begin
						kp_key      = 1'b1;
						kp_dash_cnt = kp_dash_cnt + 1'b1;
						if (kp_dash_cnt >= DASH_LENGTH) begin
							kp_dash_cnt = '0;
							kp_pending  = PH_GAP_DASH;
						end else begin
							kp_pending = PH_DASH;
						end
					end
					PH_GAP_DOT, PH_GAP_DASH: kp_key = 1'b0;
					default: begin
						kp_phase   = PH_IDLE;
						kp_pending = PH_IDLE;
						kp_key     = 1'b0;
					end
				endcase
			end else begin
				kp_count = kp_count + 1'b1;
			end
		end
		// new speed only counts from the next wrap
		if (w.speed_valid)
			kp_reload = counter_t'((1 << COUNTER_WIDTH) - w.speed_value);
		// paddle polling, the opposite element first
		case (kp_phase)
			PH_GAP_DASH:
				kp_pending = w.dot_pressed ? PH_DOT : (w.dash_pressed ? PH_DASH : PH_IDLE);
			PH_IDLE, PH_GAP_DOT:
				kp_pending = w.dash_pressed ? PH_DASH : (w.dot_pressed ? PH_DOT : PH_IDLE);
			default: ;
		endcase
		r.key_on  = kp_key;
		r.tone_on = kp_key;
		r.phase   = kp_phase;
		return r;
	endfunction

	// offers one word, possibly after a short idle, and books its result
	// once the keyer takes it
	task automatic offer_word(item_t w, bit typed, key_result_t typed_res);
		key_result_t r;
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		tick         <= w.tick;
		dot_pressed  <= w.dot_pressed;
		dash_pressed <= w.dash_pressed;
		speed_valid  <= w.speed_valid;
		speed_value  <= w.speed_value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = step_keyer(w);
		key_results_due.push_back(typed ? typed_res : r);
		words_taken++;
	endtask

	task automatic report_result(string what, key_result_t exp_r);
		if (mismatches < 10)
			$display("%s at cycle %0d: expected key=%0d tone=%0d phase=%0d, got key=%0d tone=%0d phase=%0d",
				what, cycles_run, exp_r.key_on, exp_r.tone_on, exp_r.phase,
				key_out, sidetone_on, keyer_phase);
		mismatches++;
	endtask

	initial begin : stimulus
		item_t       w;
		key_result_t none;
		bit          dot_lvl;
		bit          dash_lvl;
		bit          settle_speed;
		dot_lvl      = 1'b0;
		dash_lvl     = 1'b0;
		settle_speed = 1'b0;
		none         = '{1'b0, 1'b0, PH_IDLE};
		kp_phase     = PH_IDLE;
		kp_pending   = PH_IDLE;
		kp_dash_cnt  = '0;
		kp_count     = counter_t'(RESET_COUNT);
		kp_reload    = counter_t'(RESET_COUNT);
		kp_key       = 1'b0;

		while (!arst_n) @(posedge clk);

		// directed drill
		for (int r = 0; r < DRILL_ROWS; r++)
			for (int n = 0; n < drill[r].reps; n++)
				offer_word(drill[r].w, drill[r].typed, drill[r].res);

		// random part: paddles held for stretches like a real operator, short
		// periods so that many elements go by, long speeds mostly cancelled
		// again before a wrap can pick them up
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			calm = (i >= CALM_FROM && i < CALM_TO);
			if (i == PAUSE_AT) begin
				// let the keyer run dry before going on
				in_valid <= 1'b0;
				do @(posedge clk); while (key_results_due.size() != 0);
			end
			w      = '0;
			w.tick = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0) begin
				dot_lvl  = 1'($urandom_range(0, 1));
				dash_lvl = 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 19) == 0) begin
				// contact bounce for one word
				w.dot_pressed  = 1'($urandom_range(0, 1));
				w.dash_pressed = 1'($urandom_range(0, 1));
			end else begin
				w.dot_pressed  = dot_lvl;
				w.dash_pressed = dash_lvl;
			end
			if (settle_speed) begin
				w.tick        = 1'b0;
				w.speed_valid = 1'b1;
				w.speed_value = 8'($urandom_range(1, 4));
				settle_speed  = 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				w.speed_valid = 1'b1;
				case ($urandom_range(0, 15))
					0, 1, 2: begin
						// extremes and wide values, overwritten on the next word
						case ($urandom_range(0, 2))
							0:       w.speed_value = 8'd0;
							1:       w.speed_value = 8'd255;
							default: w.speed_value = 8'($urandom);
						endcase
						w.tick       = 1'b0;
						settle_speed = 1'b1;
					end
					3:       w.speed_value = 8'($urandom_range(5, 24));
					default: w.speed_value = 8'($urandom_range(1, 4));
				endcase
			end else if ($urandom_range(0, 19) == 0) begin
				// sample lines change without the valid flag
				w.speed_value = 8'($urandom);
			end
			offer_word(w, 1'b0, none);
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		do @(posedge clk); while (key_results_due.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls, one long hold-off so the keyer backs up
	// into its input, and none at all during the calm span
	initial begin : receiver
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && words_taken >= DRILL_ROWS + 94 + HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// result checker, one taken word against the oldest booked result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (key_results_due.size() == 0) begin
				report_result("unexpected word", '{1'b0, 1'b0, PH_IDLE});
			end else begin
				want = key_results_due.pop_front();
				if (key_out !== want.key_on || sidetone_on !== want.tone_on ||
					keyer_phase !== want.phase)
					report_result("mismatch", want);
			end
		end
	end

	// watchdog
	initial begin : watchdog
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/kyr_pkg.sv
sv/kyr_core.sv
sv/iambic_keyer_unit.sv
dv/tb_iambic_keyer_unit.sv
